/* hw/rtl/blpe_pkg.sv */
// Shared types, constants and the palette expansion for the line pixel engine.
`timescale 1ns / 1ps
`default_nettype none

package blpe_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_SCREEN_DIM = 4096;
  localparam int COLOR_BITS     = 8;
  localparam int SIZE_BITS      = 13;
  localparam int PITCH_BITS     = 15;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_IDX_BITS   = 2;
  localparam int OFFSET_BITS    = 26;
  localparam int VALUE_BITS     = 24;

  // Clip bound and on-screen coordinate widths.
  localparam int DIM_BITS = $clog2(MAX_SCREEN_DIM + 1);
  localparam int ROW_BITS = $clog2(MAX_SCREEN_DIM);

  localparam int ERR_BITS = COORD_BITS + 3;

  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((OFFSET_BITS + VALUE_BITS + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PITCH     = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TRUE_COLOR    = 2'd3;

  localparam logic [SIZE_BITS-1:0]  RST_SCREEN_WIDTH  = 13'd320;
  localparam logic [SIZE_BITS-1:0]  RST_SCREEN_HEIGHT = 13'd200;
  localparam logic [PITCH_BITS-1:0] RST_ROW_PITCH     = 15'd320;

  localparam logic [VALUE_BITS-1:0] BASE_COLORS [16] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };

  localparam logic [7:0] CUBE_FIRST  = 8'd16;
  localparam logic [7:0] CUBE_ROW    = 8'd36;
  localparam logic [7:0] CUBE_SIDE   = 8'd6;
  localparam logic [7:0] CUBE_LEVEL  = 8'd51;
  localparam logic [7:0] GRAY_FIRST  = 8'd232;
  localparam logic [7:0] GRAY_STEP   = 8'd10;
  localparam logic [7:0] GRAY_OFFSET = 8'd8;

  typedef struct packed {
    logic                         opcode;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0]        color_index;
  } line_cmd_t;

  // One pixel of the walk, as handed from the walker to the back end.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0]        color;
    logic                         done;
  } pix_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Palette index to 0xRRGGBB: base table, 6x6x6 cube, gray ramp.
  function automatic logic [VALUE_BITS-1:0] expand_color(input logic [COLOR_BITS-1:0] c);
    logic [7:0] k;
    logic [7:0] rem;
    logic [7:0] r_lvl;
    logic [7:0] g_lvl;
    logic [7:0] b_lvl;
    logic [7:0] gray;
    logic [VALUE_BITS-1:0] rgb;
    k     = c - CUBE_FIRST;
    r_lvl = '0;
    g_lvl = '0;
    for (int i = 1; i < 6; i++) begin
      if (k >= 8'(36 * i)) begin
        r_lvl = 8'(i);
      end
    end
    rem = k - 8'(r_lvl * CUBE_ROW);
    for (int i = 1; i < 6; i++) begin
      if (rem >= 8'(6 * i)) begin
        g_lvl = 8'(i);
      end
    end
    b_lvl = rem - 8'(g_lvl * CUBE_SIDE);
    gray  = 8'((c - GRAY_FIRST) * GRAY_STEP + GRAY_OFFSET);
    if (c < CUBE_FIRST) begin
      rgb = BASE_COLORS[c[3:0]];
    end else if (c < GRAY_FIRST) begin
      rgb = {8'(r_lvl * CUBE_LEVEL), 8'(g_lvl * CUBE_LEVEL), 8'(b_lvl * CUBE_LEVEL)};
    end else begin
      rgb = {gray, gray, gray};
    end
    return rgb;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/blpe_front.sv */
// Front end: takes requests, loads lines and walks them one pixel per step.
`timescale 1ns / 1ps
`default_nettype none

module blpe_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  input  wire blpe_pkg::line_cmd_t cmd_i,
  input  wire blpe_pkg::q_stat_t   q_stat_i,
  output logic                     push_o,
  output blpe_pkg::pix_req_t       push_data_o
);
  import blpe_pkg::*;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] end_x_q, end_x_d, end_y_q, end_y_d;
  logic [COORD_BITS:0]          abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  logic                         step_x_neg_q, step_x_neg_d, step_y_neg_q, step_y_neg_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic                         active_q, active_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;

  logic                         accept, start, step, done;
  logic signed [COORD_BITS:0]   ddx, ddy;
  logic [COORD_BITS:0]          adx, ady;
  logic signed [ERR_BITS:0]     e2, neg_dy, pos_dx;
  logic                         move_x, move_y;
  logic [ERR_BITS-1:0]          sub_y, add_x;

  assign s_tready_o = !q_stat_i.full;
  assign accept     = s_tvalid_i && s_tready_o;
  assign start      = accept && (cmd_i.opcode == OP_START);
  assign step       = accept && (cmd_i.opcode == OP_STEP) && active_q;
  assign done       = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);

  assign push_o            = step;
  assign push_data_o.x     = cur_x_q;
  assign push_data_o.y     = cur_y_q;
  assign push_data_o.color = color_q;
  assign push_data_o.done  = done;

  // Line setup.
  assign ddx = $signed({cmd_i.x_end[COORD_BITS-1], cmd_i.x_end})
             - $signed({cmd_i.x_start[COORD_BITS-1], cmd_i.x_start});
  assign ddy = $signed({cmd_i.y_end[COORD_BITS-1], cmd_i.y_end})
             - $signed({cmd_i.y_start[COORD_BITS-1], cmd_i.y_start});
  assign adx = ddx[COORD_BITS] ? (COORD_BITS + 1)'(-ddx) : ddx;
  assign ady = ddy[COORD_BITS] ? (COORD_BITS + 1)'(-ddy) : ddy;

  // Bresenham decision on the doubled error term.
  assign e2     = $signed({err_q, 1'b0});
  assign pos_dx = $signed({3'b000, abs_dx_q});
  assign neg_dy = -$signed({3'b000, abs_dy_q});
  assign move_x = e2 > neg_dy;
  assign move_y = e2 < pos_dx;
  assign sub_y  = move_x ? {2'b00, abs_dy_q} : '0;
  assign add_x  = move_y ? {2'b00, abs_dx_q} : '0;

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    end_x_d      = end_x_q;
    end_y_d      = end_y_q;
    abs_dx_d     = abs_dx_q;
    abs_dy_d     = abs_dy_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    err_d        = err_q;
    active_d     = active_q;
    color_d      = color_q;
    if (start) begin
      cur_x_d      = cmd_i.x_start;
      cur_y_d      = cmd_i.y_start;
      end_x_d      = cmd_i.x_end;
      end_y_d      = cmd_i.y_end;
      abs_dx_d     = adx;
      abs_dy_d     = ady;
      step_x_neg_d = !(cmd_i.x_start < cmd_i.x_end);
      step_y_neg_d = !(cmd_i.y_start < cmd_i.y_end);
      err_d        = $signed({2'b00, adx}) - $signed({2'b00, ady});
      color_d      = cmd_i.color_index;
      active_d     = 1'b1;
    end else if (step) begin
      if (done) begin
        active_d = 1'b0;
      end else begin
        err_d = err_q - $signed(sub_y) + $signed(add_x);
        if (move_x) begin
          cur_x_d = cur_x_q + (step_x_neg_q ? '1 : COORD_BITS'(1));
        end
        if (move_y) begin
          cur_y_d = cur_y_q + (step_y_neg_q ? '1 : COORD_BITS'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      end_x_q      <= '0;
      end_y_q      <= '0;
      abs_dx_q     <= '0;
      abs_dy_q     <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      err_q        <= '0;
      active_q     <= 1'b0;
      color_q      <= '0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      end_x_q      <= end_x_d;
      end_y_q      <= end_y_d;
      abs_dx_q     <= abs_dx_d;
      abs_dy_q     <= abs_dy_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      err_q        <= err_d;
      active_q     <= active_d;
      color_q      <= color_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/blpe_queue.sv */
// Small pixel queue between the line walker and the pixel back end.
`timescale 1ns / 1ps
`default_nettype none

module blpe_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire blpe_pkg::pix_req_t push_data_i,
  input  wire logic               pop_i,
  output blpe_pkg::pix_req_t      pop_data_o,
  output blpe_pkg::q_stat_t       q_stat_o
);
  import blpe_pkg::*;

  pix_req_t             entries_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   count_q, count_d;

  assign q_stat_o.full  = (count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign q_stat_o.empty = (count_q == '0);
  assign pop_data_o     = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_BITS'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_BITS + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/blpe_back.sv */
// Back end: screen clip, framebuffer offset, color expansion and output register.
`timescale 1ns / 1ps
`default_nettype none

module blpe_back (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [blpe_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  wire logic [blpe_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  wire blpe_pkg::q_stat_t                      q_stat_i,
  input  wire blpe_pkg::pix_req_t                     pop_data_i,
  output logic                                        pop_o,
  output logic                                        m_tvalid_o,
  input  wire logic                                   m_tready_i,
  output logic [blpe_pkg::OFFSET_BITS-1:0]            pixel_offset_o,
  output logic [blpe_pkg::VALUE_BITS-1:0]             pixel_value_o,
  output logic                                        write_enable_o,
  output logic                                        line_done_o
);
  import blpe_pkg::*;

  localparam int PROD_BITS = ROW_BITS + PITCH_BITS;

  logic [SIZE_BITS-1:0]  width_q, height_q;
  logic [PITCH_BITS-1:0] pitch_q;
  logic                  true_color_q;

  logic                  out_valid_q, out_valid_d;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  we_q, done_q;

  logic [DIM_BITS-1:0]   bound_w, bound_h;
  logic                  on_screen;
  logic [ROW_BITS-1:0]   row, col;
  logic [PITCH_BITS-1:0] pitch_eff;
  logic [PROD_BITS-1:0]  prod;
  logic [OFFSET_BITS-1:0] offset;
  logic [VALUE_BITS-1:0] value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= RST_SCREEN_WIDTH;
      height_q     <= RST_SCREEN_HEIGHT;
      pitch_q      <= RST_ROW_PITCH;
      true_color_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_WIDTH:  width_q      <= cfg_data_i[SIZE_BITS-1:0];
        CFG_SCREEN_HEIGHT: height_q     <= cfg_data_i[SIZE_BITS-1:0];
        CFG_ROW_PITCH:     pitch_q      <= cfg_data_i[PITCH_BITS-1:0];
        CFG_TRUE_COLOR:    true_color_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Screen sizes above the largest supported dimension clip at that dimension.
  assign bound_w = (32'(width_q) > MAX_SCREEN_DIM) ? DIM_BITS'(MAX_SCREEN_DIM)
                                                  : DIM_BITS'(width_q);
  assign bound_h = (32'(height_q) > MAX_SCREEN_DIM) ? DIM_BITS'(MAX_SCREEN_DIM)
                                                   : DIM_BITS'(height_q);

  assign on_screen = !pop_data_i.x[COORD_BITS-1] && !pop_data_i.y[COORD_BITS-1]
                  && (32'(unsigned'(pop_data_i.x)) < 32'(bound_w))
                  && (32'(unsigned'(pop_data_i.y)) < 32'(bound_h));

  // On screen both coordinates are below the clip bound, so few bits suffice.
  assign row       = ROW_BITS'(unsigned'(pop_data_i.y));
  assign col       = ROW_BITS'(unsigned'(pop_data_i.x));
  assign pitch_eff = true_color_q ? {2'b00, pitch_q[PITCH_BITS-1:2]} : pitch_q;
  assign prod      = PROD_BITS'(row) * PROD_BITS'(pitch_eff);
  assign offset    = on_screen ? OFFSET_BITS'(prod) + OFFSET_BITS'(col) : '0;
  assign value     = true_color_q ? expand_color(pop_data_i.color)
                                  : VALUE_BITS'(pop_data_i.color);

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || m_tready_i);
  assign out_valid_d = pop_o ? 1'b1 : (m_tready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      offset_q <= offset;
      value_q  <= value;
      we_q     <= on_screen;
      done_q   <= pop_data_i.done;
    end
  end

  assign m_tvalid_o     = out_valid_q;
  assign pixel_offset_o = offset_q;
  assign pixel_value_o  = value_q;
  assign write_enable_o = we_q;
  assign line_done_o    = done_q;

endmodule

`default_nettype wire

/* hw/rtl/bresenham_line_pixel_engine.sv */
// Top level of the Bresenham line pixel engine: walker, pixel queue and back end.
//
//   Channel  Direction  Signals                            Contents
//   s        in         s_tvalid/s_tready/s_tdata/s_tuser  start or step request
//   m        out        m_tvalid/m_tready/m_tdata/m_tuser  one pixel write
//                       /m_tlast
//   cfg      in         cfg_we_i/cfg_idx_i/cfg_data_i      register writes
//
// One request is taken per cycle while the queue is not full; a step of an active line is
// written to a queue entry, then to the back-end output register, which drives m.
// The walker advances one Bresenham step per cycle while steps are taken; a four-entry queue
// decouples it from the offset multiplier and output register, so downstream stalls only
// stop input once the queue is full. Reset leaves the block idle with default registers.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_pixel_engine (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // x_start, y_start, x_end, y_end, color_index
  input  wire logic [blpe_pkg::IN_DATA_BITS-1:0]     s_tdata,
  // opcode
  input  wire logic                                  s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // pixel_offset, pixel_value, zero fill
  output logic [blpe_pkg::OUT_DATA_BITS-1:0]         m_tdata,
  // write_enable
  output logic                                       m_tuser,
  output logic                                       m_tlast,
  input  wire logic                                  cfg_we_i,
  input  wire logic [blpe_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  wire logic [blpe_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import blpe_pkg::*;

  line_cmd_t              cmd;
  q_stat_t                q_stat;
  pix_req_t               push_data, pop_data;
  logic                   q_push, q_pop;
  logic [OFFSET_BITS-1:0] pixel_offset;
  logic [VALUE_BITS-1:0]  pixel_value;

  assign cmd.opcode      = s_tuser;
  assign cmd.x_start     = s_tdata[0 +: COORD_BITS];
  assign cmd.y_start     = s_tdata[COORD_BITS +: COORD_BITS];
  assign cmd.x_end       = s_tdata[2 * COORD_BITS +: COORD_BITS];
  assign cmd.y_end       = s_tdata[3 * COORD_BITS +: COORD_BITS];
  assign cmd.color_index = s_tdata[4 * COORD_BITS +: COLOR_BITS];

  blpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .cmd_i       (cmd),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (push_data)
  );

  blpe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  blpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .q_stat_i       (q_stat),
    .pop_data_i     (pop_data),
    .pop_o          (q_pop),
    .m_tvalid_o     (m_tvalid),
    .m_tready_i     (m_tready),
    .pixel_offset_o (pixel_offset),
    .pixel_value_o  (pixel_value),
    .write_enable_o (m_tuser),
    .line_done_o    (m_tlast)
  );

  assign m_tdata = OUT_DATA_BITS'({pixel_value, pixel_offset});

`ifndef SYNTHESIS
  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("pixel queue written while full");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pixel queue read while empty");

  a_clipped_offset_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tuser) |-> (m_tdata[OFFSET_BITS-1:0] == '0))
    else $error("clipped pixel carries a nonzero offset");
`endif

endmodule

`default_nettype wire
